// ===== hw/rtl/series_and_newton_function_unit_defines.svh =====
// Assertion macros for the series and Newton function unit
`ifndef SERIES_AND_NEWTON_FUNCTION_UNIT_DEFINES_SVH
`define SERIES_AND_NEWTON_FUNCTION_UNIT_DEFINES_SVH

// a condition implies another at the same edge
`define SNF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// a condition implies another at the next edge
`define SNF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/snf_pkg.sv =====
// Package: types, constants and codes of the series and Newton function unit
`default_nettype none
package snf_pkg;
    localparam int FRAC_BITS = 24;
    localparam int MAX_TERMS = 32;
    localparam int MAX_ITER  = 32;
    localparam int TERM_W    = 6;
    localparam int ITER_W    = 6;
    localparam int TOL_W     = 25;
    localparam logic [TOL_W-1:0] TOL_RESET = 25'd1678;
    // dividend is up to 64 bits (|term|*|x| or x<<FRAC_BITS)
    localparam int DIV_W     = 64;
    localparam int DCNT_W    = 7;

    localparam logic [1:0] OP_SIN   = 2'd0;
    localparam logic [1:0] OP_EXP   = 2'd1;
    localparam logic [1:0] OP_SQRT  = 2'd2;
    localparam logic [1:0] OP_UNDEF = 2'd3;  // no operation defined

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_NOCNV = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] arg_x;
        logic [5:0]         term_count;
        logic signed [31:0] start_guess;
    } req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, init term/sum/guess
        logic mul;       // product |term|*|x| into dividend
        logic sq_prep;   // x<<FRAC into dividend, guess as divisor
        logic div_start; // begin a division
        logic ser_upd;   // apply series step from quotient
        logic nw_upd;    // apply Newton step from quotient
        logic fin;       // form the result
    } snf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
        logic bad;       // operand check failed
        logic ser_last;  // series index reached n
        logic nw_done;   // converged
        logic nw_last;   // iteration cap reached
    } snf_sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/snf_ctrl.sv =====
// Controller state machine of the series and Newton function unit
`default_nettype none
module snf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_go,
    input  wire logic [1:0]        op,
    input  wire snf_pkg::snf_sts_t sts,
    input  wire logic              out_free,
    output snf_pkg::snf_cmd_t      cmd,
    output logic                   idle,
    output logic                   res_valid
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // sequencing
    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_go)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.bad)
                    state_next = S_FIN;
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (op == snf_pkg::OP_SQRT)
                    cmd.sq_prep = 1'b1;
                else
                    cmd.mul = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    if (op == snf_pkg::OP_SQRT)
                    begin
                        cmd.nw_upd = 1'b1;
                        state_next = (sts.nw_done || sts.nw_last) ? S_FIN : S_MUL;
                    end
                    else
                    begin
                        cmd.ser_upd = 1'b1;
                        state_next = sts.ser_last ? S_FIN : S_MUL;
                    end
                end
            end
            S_FIN:
            begin
                cmd.fin = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign idle = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
endmodule
`default_nettype wire

// ===== hw/rtl/snf_div.sv =====
// Restoring radix-2 unsigned divider, one quotient bit per cycle
`default_nettype none
module snf_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [snf_pkg::DIV_W-1:0] dividend,
    input  wire logic [snf_pkg::DIV_W-1:0] divisor,
    output logic                           busy,
    output logic [snf_pkg::DIV_W-1:0]      quotient
);
    localparam int W = snf_pkg::DIV_W;
    logic [W-1:0] quo_reg;
    logic [W:0]   rem_reg;
    logic [W-1:0] dvs_reg;
    logic [snf_pkg::DCNT_W-1:0] cnt_reg;
    logic busy_reg;
    logic [W:0] shifted, diff;

    assign shifted = {rem_reg[W-1:0], quo_reg[W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= snf_pkg::DCNT_W'(W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == snf_pkg::DCNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    // shift-subtract step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg || start;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/snf_dpath.sv =====
// Datapath: term, sum, guess registers, multiplier and divider
`default_nettype none
module snf_dpath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire snf_pkg::snf_cmd_t             cmd,
    input  wire snf_pkg::req_t                 req,
    input  wire logic [snf_pkg::TOL_W-1:0]     tol,
    output snf_pkg::snf_sts_t                  sts,
    output logic [1:0]                         op,
    output snf_pkg::rsp_t                      rsp
);
    localparam int F = snf_pkg::FRAC_BITS;
    localparam logic signed [39:0] POS_MAX = 40'sd2147483647;
    localparam logic signed [39:0] NEG_MIN = -40'sd2147483648;

    logic [1:0]         op_reg;
    logic signed [31:0] x_reg;
    logic [5:0]         n_reg;
    logic [5:0]         i_reg;
    logic signed [31:0] term_reg;   // running term, or Newton guess
    logic signed [39:0] sum_reg;    // 32 terms of 32 bits fit in 38
    logic               sat_reg;
    logic               bad_reg;
    logic               done_reg;
    logic [63:0]        dvd_reg;
    logic [63:0]        dvs_reg;
    logic               neg_reg;
    logic               start_reg;
    snf_pkg::rsp_t      rsp_reg;
    logic [63:0]        quo;
    logic               div_busy;

    snf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .busy     (div_busy),
        .quotient (quo)
    );

    logic [31:0] mag_t, mag_x;
    assign mag_t = term_reg[31] ? 32'(-term_reg) : 32'(term_reg);
    assign mag_x = x_reg[31] ? 32'(-x_reg) : 32'(x_reg);

    // series step: signed quotient, clamped to 32 bits
    logic signed [39:0] qs;
    logic               q_big;
    logic signed [31:0] step_val;
    logic               step_sat;
    always_comb
    begin
        q_big = |quo[63:33];
        qs = neg_reg ? -$signed({7'd0, quo[32:0]}) : $signed({7'd0, quo[32:0]});
        step_sat = 1'b0;
        if (q_big || qs > POS_MAX)
        begin
            step_sat = q_big || qs > POS_MAX;
            step_val = neg_reg ? 32'sh80000000 : 32'sh7fffffff;
            if (neg_reg && !q_big && qs >= NEG_MIN)
            begin
                step_val = 32'(qs);
                step_sat = 1'b0;
            end
        end
        else if (qs < NEG_MIN)
        begin
            step_sat = 1'b1;
            step_val = 32'sh80000000;
        end
        else
            step_val = 32'(qs);
    end

    // Newton step
    logic [64:0] nsum;
    logic [63:0] s_half;
    logic signed [31:0] ng;
    logic signed [32:0] gdiff;
    logic [32:0] adiff;
    always_comb
    begin
        nsum = {33'd0, term_reg} + {1'b0, quo};
        s_half = nsum[64:1];
        ng = (|s_half[63:31]) ? 32'sh7fffffff : $signed(s_half[31:0]);
        gdiff = 33'(ng) - 33'(term_reg);
        adiff = gdiff[32] ? 33'(-gdiff) : 33'(gdiff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_reg <= 1'b0;
        else
            start_reg <= cmd.div_start;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= req.req_type;
            x_reg    <= req.arg_x;
            n_reg    <= (req.term_count > 6'(snf_pkg::MAX_TERMS)) ?
                        6'(snf_pkg::MAX_TERMS) : req.term_count;
            i_reg    <= 6'd1;
            sat_reg  <= 1'b0;
            done_reg <= 1'b0;
            if (req.req_type == snf_pkg::OP_SQRT)
            begin
                term_reg <= req.start_guess;
                bad_reg  <= req.arg_x[31] || req.start_guess[31] || req.start_guess == 0;
                sum_reg  <= '0;
            end
            else
            begin
                term_reg <= 32'sd1 <<< F;
                sum_reg  <= (req.req_type == snf_pkg::OP_EXP) ? (40'sd1 <<< F) : '0;
                bad_reg  <= (req.req_type == snf_pkg::OP_UNDEF) || req.term_count < 6'd2;
            end
        end
        if (cmd.mul)
        begin
            dvd_reg <= 64'(mag_t) * 64'(mag_x);
            dvs_reg <= 64'(i_reg) << F;
            neg_reg <= term_reg[31] ^ x_reg[31];
        end
        if (cmd.sq_prep)
        begin
            dvd_reg <= 64'(x_reg) << F;
            dvs_reg <= 64'(term_reg);
        end
        if (cmd.ser_upd)
        begin
            term_reg <= step_val;
            if (step_sat)
                sat_reg <= 1'b1;
            if (op_reg == snf_pkg::OP_EXP || i_reg[1:0] == 2'd1)
                sum_reg <= sum_reg + 40'(step_val);
            else if (i_reg[1:0] == 2'd3)
                sum_reg <= sum_reg - 40'(step_val);
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.nw_upd)
        begin
            term_reg <= ng;
            i_reg    <= i_reg + 1'b1;
            if (adiff <= 33'(tol) || ng == 0)
                done_reg <= 1'b1;
        end
        if (cmd.fin)
        begin
            if (bad_reg)
            begin
                rsp_reg.value  <= '0;
                rsp_reg.status <= snf_pkg::ST_BAD;
            end
            else if (op_reg == snf_pkg::OP_SQRT)
            begin
                rsp_reg.value  <= term_reg;
                rsp_reg.status <= done_reg ? snf_pkg::ST_OK : snf_pkg::ST_NOCNV;
            end
            else if (sum_reg > POS_MAX)
            begin
                rsp_reg.value  <= 32'sh7fffffff;
                rsp_reg.status <= snf_pkg::ST_SAT;
            end
            else if (sum_reg < NEG_MIN)
            begin
                rsp_reg.value  <= 32'sh80000000;
                rsp_reg.status <= snf_pkg::ST_SAT;
            end
            else
            begin
                rsp_reg.value  <= 32'(sum_reg);
                rsp_reg.status <= sat_reg ? snf_pkg::ST_SAT : snf_pkg::ST_OK;
            end
        end
    end

    // status: nw flags look at the update being applied this cycle
    assign sts.div_busy = div_busy;
    assign sts.bad      = bad_reg;
    assign sts.ser_last = (i_reg == n_reg);
    assign sts.nw_done  = (adiff <= 33'(tol)) || ng == 0;
    assign sts.nw_last  = (i_reg == 6'(snf_pkg::MAX_ITER));
    assign op  = op_reg;
    assign rsp = rsp_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/series_and_newton_function_unit.sv =====
// Top level of the series and Newton function unit
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/in_stall | snf_pkg::req_t
//  out     | output    | out_valid/out_stall | snf_pkg::rsp_t
//  cfg     | input     | cfg_valid/cfg_ready | tolerance, 25 bits
// One item at a time. Each series term or Newton iteration runs one
// division in the 64-bit one-bit-per-cycle divider. Bad operands go from
// the check state straight to forming the result. Reset loads tolerance
// 1678; no clearing pass. The result holds in its register while
// out_stall is high and no new item is taken until it leaves.
`default_nettype none
`include "series_and_newton_function_unit_defines.svh"
module series_and_newton_function_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire snf_pkg::req_t               in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output snf_pkg::rsp_t                    out_data,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [snf_pkg::TOL_W-1:0]   cfg_data
);
    logic [snf_pkg::TOL_W-1:0] tol_reg;
    snf_pkg::snf_cmd_t cmd;
    snf_pkg::snf_sts_t sts;
    logic [1:0] op;
    logic idle;
    logic in_go;

    assign cfg_ready = 1'b1;
    assign in_stall  = !idle;
    assign in_go     = in_valid && idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= snf_pkg::TOL_RESET;
        else if (cfg_valid && cfg_ready)
            tol_reg <= cfg_data;
    end

    snf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_go     (in_go),
        .op        (op),
        .sts       (sts),
        .out_free  (!out_stall),
        .cmd       (cmd),
        .idle      (idle),
        .res_valid (out_valid)
    );

    snf_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (in_data),
        .tol   (tol_reg),
        .sts   (sts),
        .op    (op),
        .rsp   (out_data)
    );

    `SNF_ASSERT_IMPL(a_no_accept_busy, out_valid, in_stall, "input taken while result pending")
    `SNF_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall && !out_valid, "accept did not start work")
    `SNF_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0({cmd.mul, cmd.sq_prep, cmd.ser_upd, cmd.nw_upd, cmd.fin}), "conflicting datapath commands")
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the series and Newton function unit: directed and random requests
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    snf_pkg::req_t in_data;
    logic out_valid;
    logic out_stall;
    snf_pkg::rsp_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [snf_pkg::TOL_W-1:0] cfg_data;

    series_and_newton_function_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint NEG_MIN = -64'sd2147483648;
    localparam longint CYCLE_LIMIT = 64'd6000000;

    // model copy of the tolerance register
    logic [snf_pkg::TOL_W-1:0] tol_model;
    snf_pkg::rsp_t    pending_rsp[$];
    int               fail_count;
    int               rsp_count;
    int               req_count;
    longint           cycle_count;
    bit               idle_on;
    int               hold_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // clamp to signed 32 bits, flagging saturation
    function automatic longint clamp_s32(input longint v, inout bit sat);
        if (v > POS_MAX)
        begin
            sat = 1'b1;
            return POS_MAX;
        end
        if (v < NEG_MIN)
        begin
            sat = 1'b1;
            return NEG_MIN;
        end
        return v;
    endfunction

    // expected result of one request
    function automatic snf_pkg::rsp_t calc_function(input snf_pkg::req_t r);
        snf_pkg::rsp_t o;
        longint  x;
        longint  g;
        longint  term;
        longint  sum;
        longint  ng;
        longint  diff;
        longint  qs;
        bit      sat;
        bit      neg;
        bit      done;
        int      n;
        logic [63:0] q;
        logic [63:0] s;
        logic [63:0] mx;
        logic [63:0] mt;
        x = longint'(r.arg_x);
        g = longint'(r.start_guess);
        n = r.term_count;
        sat = 1'b0;
        o.value = '0;
        o.status = snf_pkg::ST_OK;
        if (r.req_type == snf_pkg::OP_SIN || r.req_type == snf_pkg::OP_EXP)
        begin
            if (n < 2)
                o.status = snf_pkg::ST_BAD;
            else
            begin
                if (n > snf_pkg::MAX_TERMS)
                    n = snf_pkg::MAX_TERMS;
                term = 64'sd1 << snf_pkg::FRAC_BITS;
                sum = (r.req_type == snf_pkg::OP_EXP) ? term : 0;
                for (int i = 1; i <= n; i++)
                begin
                    neg = (term < 0) != (x < 0);
                    mt = (term < 0) ? -term : term;
                    mx = (x < 0) ? -x : x;
                    q = (mt * mx) / (64'(i) << snf_pkg::FRAC_BITS);
                    qs = neg ? -longint'(q) : longint'(q);
                    term = clamp_s32(qs, sat);
                    if (r.req_type == snf_pkg::OP_EXP)
                        sum += term;
                    else if (i % 4 == 1)
                        sum += term;
                    else if (i % 4 == 3)
                        sum -= term;
                end
                o.value = 32'(clamp_s32(sum, sat));
                o.status = sat ? snf_pkg::ST_SAT : snf_pkg::ST_OK;
            end
        end
        else if (r.req_type == snf_pkg::OP_SQRT)
        begin
            if (x < 0 || g <= 0)
                o.status = snf_pkg::ST_BAD;
            else
            begin
                done = 1'b0;
                for (int it = 0; it < snf_pkg::MAX_ITER && !done; it++)
                begin
                    q = (64'(x) << snf_pkg::FRAC_BITS) / 64'(g);
                    s = (64'(g) + q) >> 1;
                    if (s > 64'(POS_MAX))
                        s = 64'(POS_MAX);
                    ng = longint'(s);
                    diff = ng - g;
                    if (diff < 0)
                        diff = -diff;
                    g = ng;
                    if (diff <= longint'(tol_model) || g == 0)
                        done = 1'b1;
                end
                o.value = 32'(g);
                o.status = done ? snf_pkg::ST_OK : snf_pkg::ST_NOCNV;
            end
        end
        else
            o.status = snf_pkg::ST_BAD;
        return o;
    endfunction

    // random idle decision for either side
    function automatic bit idle_now();
        return idle_on && ($urandom_range(99) < 15);
    endfunction

    // send one request and record its expected result
    task automatic send_req(input snf_pkg::req_t r);
        // valid is low between one item and the next
        @(negedge clk);
        while (idle_now())
            @(negedge clk);
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_rsp.push_back(calc_function(r));
        req_count++;
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic send_fields(input logic [1:0] op, input logic [31:0] x,
                               input logic [5:0] n, input logic [31:0] g);
        snf_pkg::req_t r;
        r.req_type = op;
        r.arg_x = x;
        r.term_count = n;
        r.start_guess = g;
        send_req(r);
    endtask

    // wait until idle, then write tolerance
    task automatic write_tolerance(input logic [snf_pkg::TOL_W-1:0] t);
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (20)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= t;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tol_model = t;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver stall
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= idle_now();
    end

    // result checker
    always @(posedge clk)
    begin
        snf_pkg::rsp_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            rsp_count++;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t unexpected result value=%h status=%0d", $time,
                         out_data.value, out_data.status);
                fail_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (want.value !== out_data.value)
                begin
                    $display("%0t value: expected %h actual %h", $time,
                             want.value, out_data.value);
                    fail_count++;
                end
                if (want.status !== out_data.status)
                begin
                    $display("%0t status: expected %0d actual %0d", $time,
                             want.status, out_data.status);
                    fail_count++;
                end
            end
        end
    end

    // timeout
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("series_and_newton_function_unit: mismatch");
            $finish;
        end
    end

    // field extremes, all operations, bad operands
    task automatic test_directed();
        send_fields(snf_pkg::OP_SIN, 32'h0000_0000, 6'd2, 32'd0);
        send_fields(snf_pkg::OP_SIN, 32'h0100_0000, 6'd10, 32'd0);
        send_fields(snf_pkg::OP_SIN, 32'hFF00_0000, 6'd32, 32'd0);
        send_fields(snf_pkg::OP_SIN, 32'h7FFF_FFFF, 6'd63, 32'd0);
        send_fields(snf_pkg::OP_SIN, 32'h8000_0000, 6'd5, 32'd0);
        send_fields(snf_pkg::OP_SIN, 32'h0100_0000, 6'd1, 32'd0);
        send_fields(snf_pkg::OP_EXP, 32'h0000_0000, 6'd0, 32'd0);
        send_fields(snf_pkg::OP_EXP, 32'h0100_0000, 6'd20, 32'd0);
        send_fields(snf_pkg::OP_EXP, 32'h0500_0000, 6'd32, 32'd0);
        send_fields(snf_pkg::OP_EXP, 32'hF800_0000, 6'd40, 32'd0);
        send_fields(snf_pkg::OP_EXP, 32'h7FFF_FFFF, 6'd3, 32'd0);
        send_fields(snf_pkg::OP_EXP, 32'h8000_0000, 6'd63, 32'd0);
        send_fields(snf_pkg::OP_SQRT, 32'h0200_0000, 6'd0, 32'h0100_0000);
        send_fields(snf_pkg::OP_SQRT, 32'h0000_0000, 6'd0, 32'h0100_0000);
        send_fields(snf_pkg::OP_SQRT, 32'h7FFF_FFFF, 6'd63, 32'h7FFF_FFFF);
        send_fields(snf_pkg::OP_SQRT, 32'h7FFF_FFFF, 6'd0, 32'h0000_0001);
        send_fields(snf_pkg::OP_SQRT, 32'h0000_0001, 6'd0, 32'h7FFF_FFFF);
        send_fields(snf_pkg::OP_SQRT, 32'hFFFF_FFFF, 6'd0, 32'h0100_0000);
        send_fields(snf_pkg::OP_SQRT, 32'h0100_0000, 6'd0, 32'h0000_0000);
        send_fields(snf_pkg::OP_SQRT, 32'h0100_0000, 6'd0, 32'h8000_0000);
        send_fields(snf_pkg::OP_UNDEF, 32'h0100_0000, 6'd10, 32'h0100_0000);
    endtask

    // random requests, mostly well formed
    task automatic test_random(input int count);
        snf_pkg::req_t r;
        int   sel;
        for (int k = 0; k < count; k++)
        begin
            r.req_type = 2'($urandom_range(2));
            sel = $urandom_range(9);
            if (sel < 6)
                r.arg_x = $signed(32'($urandom_range(32'h0400_0000))) -
                          ((r.req_type == snf_pkg::OP_SQRT) ? 0 : 32'sh0200_0000);
            else
                r.arg_x = $urandom;
            // mostly short series to keep the run fast
            r.term_count = ($urandom_range(9) == 0) ? 6'($urandom) :
                           6'($urandom_range(12, 2));
            r.start_guess = (sel < 8) ? 32'($urandom_range(32'h7FFF_FFFF, 1)) :
                            $urandom;
            if ($urandom_range(19) == 0)
                r.req_type = snf_pkg::OP_UNDEF;
            send_req(r);
        end
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        hold_cycles = 4000;
        for (int k = 0; k < 6; k++)
            send_fields(snf_pkg::OP_EXP, $urandom_range(32'h0100_0000), 6'd4, 32'd1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        fail_count = 0;
        rsp_count = 0;
        req_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        idle_on = 1'b1;
        tol_model = snf_pkg::TOL_RESET;
        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        // no idling for a while
        idle_on = 1'b0;
        test_random(80);
        idle_on = 1'b1;
        write_tolerance(25'd0);
        test_directed();
        test_random(100);
        write_tolerance(25'h1FF_FFFF);
        test_random(60);
        write_tolerance(25'd16777216);
        test_random(60);
        write_tolerance(25'($urandom_range(25'h1_0000)));
        test_random(60);
        write_tolerance(snf_pkg::TOL_RESET);
        test_random(100);
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (100)
            @(negedge clk);
        $display("covered %0d requests and %0d results: sine, exp, root,", req_count,
                 rsp_count);
        $display("bad operands, saturation, six tolerance settings and output stalls");
        if (fail_count == 0 && pending_rsp.size() == 0)
            $display("series_and_newton_function_unit: match");
        else
            $display("series_and_newton_function_unit: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/snf_pkg.sv
hw/rtl/snf_ctrl.sv
hw/rtl/snf_div.sv
hw/rtl/snf_dpath.sv
hw/rtl/series_and_newton_function_unit.sv
test/tb_top.sv
